[hw/rtl/unix_time_to_calendar_date_assert.svh]
// assertion helpers for the unix time to calendar date block
`ifndef UNIX_TIME_TO_CALENDAR_DATE_ASSERT_SVH
`define UNIX_TIME_TO_CALENDAR_DATE_ASSERT_SVH

`ifndef SYNTHESIS
// plain property, checked on every edge outside reset
`define UTCD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// same-cycle implication
`define UTCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define UTCD_ASSERT(lbl, clk, rstn, prop, msg)
`define UTCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hw/rtl/utcd_pkg.sv]
package utcd_pkg;

  // pipeline layout
  localparam int unsigned DivLast   = 4;            // days and second of day ready
  localparam int unsigned TodLast   = 8;            // hour, minute, second ready
  localparam int unsigned DateLast  = 12;           // year, month, day ready
  localparam int unsigned NumStages = DateLast + 5; // weekday takes four more

  typedef logic [37:0] useconds_t;
  typedef logic [13:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  mday_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [5:0]  second_t;
  typedef logic [2:0]  wday_t;
  typedef logic [21:0] days_t;
  typedef logic [16:0] dayrem_t;

  typedef logic [NumStages-1:0] stage_vec_t;

  typedef struct packed {
    stage_vec_t en;   // stage register loads this cycle
    stage_vec_t vld;  // stage register holds a live word
  } pipe_ctl_t;

  typedef struct packed {
    hour_t   hour;
    minute_t minute;
    second_t second;
  } tod_t;

  typedef struct packed {
    year_t  year;
    month_t month;
    mday_t  day;
  } date_t;

  localparam useconds_t MaxSeconds = 38'd253402300799;
  localparam dayrem_t   SecPerDay  = 17'd86400;
  // seconds per day is 128 times this
  localparam logic [9:0] DayOdd    = 10'd675;

  // reciprocals: for an n of N bits and a divisor d of L bits,
  // floor(n * ceil(2^(N+L) / d) / 2^(N+L)) equals floor(n / d)
  localparam logic [31:0] MulDay  = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
  localparam logic [24:0] MulA    = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
  localparam logic [27:0] MulC    = 28'(((64'd1 << 40) + 64'd7304) / 64'd7305);
  localparam logic [20:0] MulE    = 21'(((64'd1 << 35) + 64'd30600) / 64'd30601);
  localparam logic [17:0] MulHr   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MulMin  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [14:0] MulCent = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
  localparam logic [10:0] Mul7    = 11'(((64'd1 << 13) + 64'd6) / 64'd7);

  // floor(601 * e / 1000)
  function automatic logic [3:0] frac601(logic [3:0] e);
    logic [3:0] r;
    case (e)
      4'd0, 4'd1:   r = 4'd0;
      4'd2, 4'd3:   r = 4'd1;
      4'd4:         r = 4'd2;
      4'd5, 4'd6:   r = 4'd3;
      4'd7, 4'd8:   r = 4'd4;
      4'd9:         r = 4'd5;
      4'd10, 4'd11: r = 4'd6;
      4'd12, 4'd13: r = 4'd7;
      4'd14:        r = 4'd8;
      4'd15:        r = 4'd9;
      default:      r = 4'd0;
    endcase
    return r;
  endfunction

  // floor(26 * (m + 1) / 10) for the shifted months three to fourteen
  function automatic logic [5:0] month_term(logic [3:0] m);
    logic [5:0] r;
    case (m)
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      4'd13:   r = 6'd36;
      4'd14:   r = 6'd39;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/utcd_in_if.sv]
interface utcd_in_if import utcd_pkg::*; ;
  logic      valid;
  logic      ready;
  useconds_t unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

[hw/rtl/utcd_out_if.sv]
interface utcd_out_if import utcd_pkg::*; ;
  logic    valid;
  logic    ready;
  year_t   year;
  month_t  month;
  mday_t   day;
  hour_t   hour;
  minute_t minute;
  second_t second;
  wday_t   weekday;

  modport source (
    output valid, output year, output month, output day,
    output hour, output minute, output second, output weekday,
    input ready
  );
  modport sink (
    input valid, input year, input month, input day,
    input hour, input minute, input second, input weekday,
    output ready
  );
endinterface

[hw/rtl/utcd_daydiv.sv]
`include "unix_time_to_calendar_date_assert.svh"

module utcd_daydiv import utcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  useconds_t unix_seconds_i,
  output days_t     days_o,
  output dayrem_t   rem_o
);

  useconds_t   tsat;
  logic [30:0] n0_q;    // seconds in units of 128
  logic [6:0]  lo0_q;   // seconds below 128
  logic [46:0] ph1_q;
  logic [47:0] pl1_q;
  logic [9:0]  n1_q;
  logic [6:0]  lo1_q;
  days_t       days2_q;
  logic [9:0]  n2_q;
  logic [6:0]  lo2_q;
  days_t       days3_q;
  logic [9:0]  m3_q;
  logic [9:0]  n3_q;
  logic [6:0]  lo3_q;
  days_t       days4_q;
  dayrem_t     rem4_q;

  logic [62:0] prod;
  logic [19:0] m_full;
  logic [9:0]  r_low;

  // clamp at the last second of year 9999
  assign tsat = (unix_seconds_i > MaxSeconds) ? MaxSeconds : unix_seconds_i;

  // days = floor((t >> 7) / 675), split product summed one stage later
  assign prod   = {ph1_q, 16'b0} + 63'(pl1_q);
  // remainder below 675, so ten low bits carry it exactly
  assign m_full = 20'(days2_q[9:0]) * 20'(DayOdd);
  assign r_low  = n3_q - m3_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      n0_q  <= tsat[37:7];
      lo0_q <= tsat[6:0];
    end
    if (ctl_i.en[1]) begin
      ph1_q <= 47'(n0_q[30:16]) * 47'(MulDay);
      pl1_q <= 48'(n0_q[15:0]) * 48'(MulDay);
      n1_q  <= n0_q[9:0];
      lo1_q <= lo0_q;
    end
    if (ctl_i.en[2]) begin
      days2_q <= prod[62:41];
      n2_q    <= n1_q;
      lo2_q   <= lo1_q;
    end
    if (ctl_i.en[3]) begin
      days3_q <= days2_q;
      m3_q    <= m_full[9:0];
      n3_q    <= n2_q;
      lo3_q   <= lo2_q;
    end
    if (ctl_i.en[DivLast]) begin
      days4_q <= days3_q;
      rem4_q  <= {r_low, lo3_q};
    end
  end

  assign days_o = days4_q;
  assign rem_o  = rem4_q;

  `UTCD_ASSERT_IMPL(a_rem_in_day, clk_i, rst_ni, ctl_i.vld[DivLast],
                    rem_o < SecPerDay, "second of day out of range")

endmodule

[hw/rtl/utcd_tod.sv]
`include "unix_time_to_calendar_date_assert.svh"

module utcd_tod import utcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  dayrem_t   rem_i,
  output tod_t      tod_o
);

  logic [34:0] hr_prod_q;
  dayrem_t     rem5_q;
  hour_t       hr6_q;
  logic [11:0] r2_6_q;
  logic [24:0] min_prod_q;
  hour_t       hr7_q;
  logic [11:0] r2_7_q;
  tod_t        tod_q [TodLast:NumStages-1];

  hour_t       hr6;
  logic [16:0] r2_full;
  minute_t     min8;
  logic [11:0] sec_full;

  assign hr6      = hr_prod_q[33:29];
  assign r2_full  = rem5_q - 17'(hr6) * 17'd3600;
  assign min8     = min_prod_q[23:18];
  assign sec_full = r2_7_q - 12'(min8) * 12'd60;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[DivLast + 1]) begin
      hr_prod_q <= 35'(rem_i) * 35'(MulHr);
      rem5_q    <= rem_i;
    end
    if (ctl_i.en[DivLast + 2]) begin
      hr6_q  <= hr6;
      r2_6_q <= r2_full[11:0];
    end
    if (ctl_i.en[DivLast + 3]) begin
      min_prod_q <= 25'(r2_6_q) * 25'(MulMin);
      hr7_q      <= hr6_q;
      r2_7_q     <= r2_6_q;
    end
    if (ctl_i.en[TodLast]) begin
      tod_q[TodLast] <= '{hour: hr7_q, minute: min8, second: sec_full[5:0]};
    end
    // ride along until the date side catches up
    for (int k = TodLast + 1; k < NumStages; k++) begin
      if (ctl_i.en[k]) begin
        tod_q[k] <= tod_q[k-1];
      end
    end
  end

  assign tod_o = tod_q[NumStages-1];

  `UTCD_ASSERT_IMPL(a_tod_range, clk_i, rst_ni, ctl_i.vld[TodLast], tod_q[TodLast].hour < 5'd24 && tod_q[TodLast].minute < 6'd60 && tod_q[TodLast].second < 6'd60, "time of day out of range")

endmodule

[hw/rtl/utcd_date.sv]
`include "unix_time_to_calendar_date_assert.svh"

module utcd_date import utcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  days_t     days_i,
  output date_t     date_o
);

  logic [48:0] a_prod_q;
  days_t       days5_q;
  logic [22:0] b6_q;
  logic [54:0] c_prod_q;
  logic [22:0] b7_q;
  logic [13:0] c8_q;
  logic [22:0] b8_q;
  logic [9:0]  d9_q;
  logic [13:0] c9_q;
  logic [19:0] ne10_q;
  logic [9:0]  d10_q;
  logic [13:0] c10_q;
  logic [3:0]  e11_q;
  logic [9:0]  d11_q;
  logic [13:0] c11_q;
  date_t       date_q;

  logic [23:0] n_a;
  logic [6:0]  a_val;
  logic [22:0] b_val;
  logic [26:0] n_c;
  logic [22:0] d_full;
  logic [40:0] e_prod;
  logic [9:0]  f_full;

  // century correction term
  assign n_a   = {days_i, 2'b00} + 24'd102032;
  assign a_val = a_prod_q[48:42] + 7'd15;
  assign b_val = 23'(days5_q) + 23'd2442113 + 23'(a_val) - 23'(a_val[6:2]);

  // year of the shifted calendar, then day within it
  assign n_c    = 27'({b6_q, 4'b0000}) + 27'({b6_q, 2'b00}) - 27'd2442;
  assign d_full = b8_q - 23'(c8_q) * 23'd365 - 23'(c8_q[13:2]);

  // month, then day of month
  assign e_prod = 41'(ne10_q) * 41'(MulE);
  assign f_full = d11_q - 10'(e11_q) * 10'd30 - 10'(frac601(e11_q));

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[DivLast + 1]) begin
      a_prod_q <= 49'(n_a) * 49'(MulA);
      days5_q  <= days_i;
    end
    if (ctl_i.en[DivLast + 2]) begin
      b6_q <= b_val;
    end
    if (ctl_i.en[DivLast + 3]) begin
      c_prod_q <= 55'(n_c) * 55'(MulC);
      b7_q     <= b6_q;
    end
    if (ctl_i.en[DivLast + 4]) begin
      c8_q <= c_prod_q[53:40];
      b8_q <= b7_q;
    end
    if (ctl_i.en[DivLast + 5]) begin
      d9_q <= d_full[9:0];
      c9_q <= c8_q;
    end
    if (ctl_i.en[DivLast + 6]) begin
      ne10_q <= 20'(d9_q) * 20'd1000;
      d10_q  <= d9_q;
      c10_q  <= c9_q;
    end
    if (ctl_i.en[DivLast + 7]) begin
      e11_q <= e_prod[38:35];
      d11_q <= d10_q;
      c11_q <= c10_q;
    end
    if (ctl_i.en[DateLast]) begin
      date_q.day <= f_full[4:0];
      // months past the thirteenth belong to the next year
      if (e11_q <= 4'd13) begin
        date_q.year  <= c11_q - 14'd4716;
        date_q.month <= e11_q - 4'd1;
      end else begin
        date_q.year  <= c11_q - 14'd4715;
        date_q.month <= e11_q - 4'd13;
      end
    end
  end

  assign date_o = date_q;

  `UTCD_ASSERT_IMPL(a_month_range, clk_i, rst_ni, ctl_i.vld[DateLast], date_q.month >= 4'd1 && date_q.month <= 4'd12 && date_q.day != 5'd0, "calendar date out of range")

endmodule

[hw/rtl/utcd_wday.sv]
module utcd_wday import utcd_pkg::*; (
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  date_t     date_i,
  output date_t     date_o,
  output wday_t     weekday_o
);

  logic [28:0] cent_prod_q;
  year_t       yz13_q;
  month_t      mz13_q;
  date_t       date13_q;
  logic [7:0]  s1_q;
  logic [9:0]  s2_q;
  date_t       date14_q;
  logic [20:0] w_prod_q;
  logic [9:0]  sum15_q;
  date_t       date15_q;
  wday_t       wd16_q;
  date_t       date16_q;

  logic        early;
  year_t       yz;
  month_t      mz;
  logic [6:0]  cent;
  year_t       yoc_full;
  logic [6:0]  yoc;
  logic [9:0]  sum;
  logic [6:0]  q7;
  logic [9:0]  wd_full;

  // january and february count as months of the previous year
  assign early = (date_i.month <= 4'd2);
  assign yz    = early ? date_i.year - 14'd1 : date_i.year;
  assign mz    = early ? date_i.month + 4'd12 : date_i.month;

  assign cent     = cent_prod_q[27:21];
  assign yoc_full = yz13_q - 14'(cent) * 14'd100;
  assign yoc      = yoc_full[6:0];

  assign sum     = 10'(s1_q) + s2_q;
  assign q7      = w_prod_q[19:13];
  assign wd_full = sum15_q - 10'(q7) * 10'd7 + 10'd1;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[DateLast + 1]) begin
      cent_prod_q <= 29'(yz) * 29'(MulCent);
      yz13_q      <= yz;
      mz13_q      <= mz;
      date13_q    <= date_i;
    end
    if (ctl_i.en[DateLast + 2]) begin
      s1_q     <= 8'(date13_q.day) + 8'(month_term(mz13_q)) + 8'(yoc) + 8'(yoc[6:2]);
      s2_q     <= 10'(cent) * 10'd5 + 10'(cent[6:2]) + 10'd5;
      date14_q <= date13_q;
    end
    if (ctl_i.en[DateLast + 3]) begin
      w_prod_q <= 21'(sum) * 21'(Mul7);
      sum15_q  <= sum;
      date15_q <= date14_q;
    end
    if (ctl_i.en[DateLast + 4]) begin
      wd16_q   <= wd_full[2:0];
      date16_q <= date15_q;
    end
  end

  assign date_o    = date16_q;
  assign weekday_o = wd16_q;

endmodule

[hw/rtl/unix_time_to_calendar_date.sv]
// channel  dir  handshake    word
// ts_i     in   valid/ready  unix_seconds[37:0]
// date_o   out  valid/ready  year, month, day, hour, minute, second, weekday
//
// one word per cycle in and out while date_o is ready; a taken word is
// offered on date_o from the last of 17 divide, date and weekday stages
// reset clears only the stage valid bits, data registers come up unknown
// a stage loads when it is empty or the stage after it moves, so bubbles
// close up; ts_i flows while a result waits on date_o if any stage is empty
// ready walks back through the stages combinationally, one or-gate each

`include "unix_time_to_calendar_date_assert.svh"

module unix_time_to_calendar_date import utcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  utcd_in_if.sink           ts_i,
  utcd_out_if.source        date_o
);

  stage_vec_t vld_q;
  stage_vec_t vld_d;
  stage_vec_t en;
  pipe_ctl_t  ctl;

  days_t      days;
  dayrem_t    day_rem;
  tod_t       tod;
  date_t      date_mid;
  date_t      date_out;
  wday_t      weekday;

  // stage enables: load when empty or when the downstream stage moves
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || date_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // valid bits travel with the words
  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = ts_i.valid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl = '{en: en, vld: vld_q};

  // seconds -> whole days and second of day (reciprocal multiply)
  utcd_daydiv u_daydiv (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .unix_seconds_i (ts_i.unix_seconds),
    .days_o         (days),
    .rem_o          (day_rem)
  );

  // second of day -> hour, minute, second
  utcd_tod u_tod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rem_i  (day_rem),
    .tod_o  (tod)
  );

  // day count -> year, month, day via the julian day form
  utcd_date u_date (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .days_i (days),
    .date_o (date_mid)
  );

  // zeller weekday, date fields carried alongside
  utcd_wday u_wday (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .date_i    (date_mid),
    .date_o    (date_out),
    .weekday_o (weekday)
  );

  assign ts_i.ready     = en[0];
  assign date_o.valid   = vld_q[NumStages-1];
  assign date_o.year    = date_out.year;
  assign date_o.month   = date_out.month;
  assign date_o.day     = date_out.day;
  assign date_o.hour    = tod.hour;
  assign date_o.minute  = tod.minute;
  assign date_o.second  = tod.second;
  assign date_o.weekday = weekday;

  `UTCD_ASSERT_IMPL(a_ready_when_free, clk_i, rst_ni, date_o.ready || !date_o.valid,
                    ts_i.ready, "input stalled with a free output")
  `UTCD_ASSERT_IMPL(a_result_range, clk_i, rst_ni, date_o.valid,
                    date_o.weekday != 3'd0 && date_o.year >= 14'd1970 &&
                    date_o.year <= 14'd9999, "result word out of range")
  `UTCD_ASSERT(a_full_means_blocked, clk_i, rst_ni,
               !(vld_q == '1 && !date_o.ready) || !ts_i.ready,
               "word taken into a full blocked pipe")

endmodule
